// ----- rtl/aold_pkg.sv -----
// Shared types and constants for the averaged overcurrent latch detector.
`timescale 1ns / 1ps

package aold_pkg;

  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned LEVEL_W     = 13;
  localparam int unsigned GAIN_W      = 17;
  localparam int unsigned MASK_W      = 3;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 17;
  localparam int unsigned GAIN_FRAC_W = 16;

  localparam int unsigned S_DATA_W = 40;
  localparam int unsigned M_DATA_W = 48;

  localparam logic [MASK_W-1:0]  ENABLE_RST   = 3'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_RST    = 13'd4096;
  localparam logic [GAIN_W-1:0]  GAIN_ONE_RST = 17'd19005;
  localparam logic [GAIN_W-1:0]  GAIN_TWO_RST = 17'd21823;
  localparam logic [GAIN_W-1:0]  GAIN_THR_RST = 17'd65536;
  localparam logic [MASK_W-1:0]  IMM_OFF_RST  = 3'd3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CHANNEL_ENABLE  = 3'd0,
    REG_TRIP_LEVEL_ONE  = 3'd1,
    REG_TRIP_LEVEL_TWO  = 3'd2,
    REG_TRIP_LEVEL_THR  = 3'd3,
    REG_GAIN_ONE        = 3'd4,
    REG_GAIN_TWO        = 3'd5,
    REG_GAIN_THR        = 3'd6,
    REG_IMMEDIATE_OFF   = 3'd7
  } cfg_index_t;

  typedef enum logic [1:0] {
    CH_IDLE = 2'd0,
    CH_HOLD = 2'd1,
    CH_OFF  = 2'd2
  } chan_state_t;

  // Per-channel settings handed to a trip unit.
  typedef struct packed {
    logic               enable;
    logic               immediate_off;
    logic [LEVEL_W-1:0] trip_level;
    logic [GAIN_W-1:0]  gain;
  } chan_cfg_t;

  // Pipeline strobes handed to a window unit.
  typedef struct packed {
    logic accept;
    logic advance;
  } win_ctrl_t;

endpackage

// ----- rtl/aold_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module aold_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/aold_window.sv -----
// Sample ring, running sum and boxcar mean of one current channel.
`timescale 1ns / 1ps

module aold_window #(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  aold_pkg::win_ctrl_t             ctrl,
  input  logic [$clog2(WINDOW_DEPTH)-1:0] slot,
  input  logic [$clog2(WINDOW_DEPTH)-1:0] slot_next,
  input  logic                            filled,
  input  logic [aold_pkg::SAMPLE_W-1:0]   sample,
  output logic [aold_pkg::SAMPLE_W-1:0]   mean
);
  import aold_pkg::*;

  localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned SUM_W  = $clog2(4095 * WINDOW_DEPTH + 1);
  localparam int unsigned SHIFT  = SUM_W + $clog2(WINDOW_DEPTH);
  localparam int unsigned RCP_W  = SUM_W + 1;
  localparam int unsigned PROD_W = SUM_W + RCP_W;
  // Rounded-up reciprocal: exact floor division for every sum below 2^SUM_W.
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
  localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_L);

  logic [SAMPLE_W-1:0] rd_sample;
  logic [SAMPLE_W-1:0] old_sample;
  logic [SUM_W-1:0]    running_sum;
  logic [SUM_W-1:0]    running_sum_next;
  logic [SUM_W-1:0]    s1_sum;
  logic [PROD_W-1:0]   mean_prod;

  // Read address follows the slot of the next request, so the old sample is ready on accept.
  aold_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ctrl.accept),
    .waddr (slot),
    .wdata (sample),
    .raddr (slot_next),
    .rdata (rd_sample)
  );

  // Slots not yet written since reset read as zero.
  assign old_sample       = filled ? rd_sample : '0;
  assign running_sum_next = running_sum - SUM_W'(old_sample) + SUM_W'(sample);
  assign mean_prod        = PROD_W'(s1_sum) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (ctrl.accept) begin
      running_sum <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      s1_sum <= running_sum_next;
    end
    if (ctrl.advance) begin
      mean <= mean_prod[SHIFT +: SAMPLE_W];
    end
  end

  logic unused_slot_w;
  assign unused_slot_w = (SLOT_W == 0);

endmodule

// ----- rtl/aold_trip.sv -----
// Gain scaling, trip compare and latch state of one current channel.
`timescale 1ns / 1ps

module aold_trip (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  aold_pkg::chan_cfg_t           cfg,
  input  logic                          rearm,
  input  logic [aold_pkg::SAMPLE_W-1:0] mean,
  output logic [aold_pkg::SAMPLE_W-1:0] current,
  output aold_pkg::chan_state_t         status,
  output logic                          trip,
  output logic                          delatch
);
  import aold_pkg::*;

  localparam int unsigned PROD_W = SAMPLE_W + GAIN_W;

  logic [PROD_W-1:0]   scaled_prod;
  logic [SAMPLE_W:0]   scaled;
  logic [SAMPLE_W-1:0] current_next;
  chan_state_t         armed_state;
  chan_state_t         status_next;
  logic                trip_next;
  logic                delatch_next;

  assign scaled_prod  = PROD_W'(mean) * PROD_W'(cfg.gain);
  assign scaled       = scaled_prod[GAIN_FRAC_W +: SAMPLE_W + 1];
  // Saturate anything above full scale.
  assign current_next = scaled[SAMPLE_W] ? '1 : scaled[SAMPLE_W-1:0];
  assign armed_state  = rearm ? CH_IDLE : status;

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= CH_IDLE;
    end else if (load) begin
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      current <= current_next;
      trip    <= trip_next;
      delatch <= delatch_next;
    end
  end

  always_comb begin
    status_next  = armed_state;
    trip_next    = 1'b0;
    delatch_next = 1'b0;
    unique case (armed_state) inside
      CH_IDLE: begin
        if (cfg.enable && ({1'b0, current_next} >= cfg.trip_level)) begin
          trip_next = 1'b1;
          if (cfg.immediate_off) begin
            status_next  = CH_OFF;
            delatch_next = 1'b1;
          end else begin
            status_next = CH_HOLD;
          end
        end
      end
      CH_HOLD, CH_OFF: begin
        status_next = armed_state;
      end
      default: begin
        status_next = armed_state;
      end
    endcase
  end

endmodule

// ----- rtl/averaged_overcurrent_latch_detector.sv -----
// Top level of the three-channel averaged overcurrent latch detector.
`timescale 1ns / 1ps

// Takes one set of three current conversions per cycle while the output is
// not stalled and returns one result per set through three register stages:
// the running sums update on accept, the boxcar mean (reciprocal multiply) is
// formed in the next stage, and gain scaling, trip compare and channel state
// update feed the output register.
// Sustained rate is one set per clock while m_tready keeps up, set by the
// single running-sum update and the ring RAM read, prefetched one slot ahead.
// A result waiting in the output register does not block new requests until
// the two inner stages are also full. The rings start out as zero through a
// fill flag set on the first wrap of the write slot, so no clearing pass runs
// after reset. The user writes configuration through cfg_wen, cfg_index and
// cfg_data only while the block is idle; the block does not enforce this.
module averaged_overcurrent_latch_detector #(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // sample_one[11:0], sample_two[23:12], sample_three[35:24], rearm_mask[38:36], pad[39]
  input  logic [aold_pkg::S_DATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // current_one[11:0], current_two[23:12], current_three[35:24], status_one[37:36],
  // status_two[39:38], status_three[41:40], trip_pulse_mask[44:42],
  // delatch_pulse_mask[47:45]
  output logic [aold_pkg::M_DATA_W-1:0]     m_tdata,
  input  logic                              cfg_wen,
  input  logic [aold_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [aold_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import aold_pkg::*;

  localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

  // Configuration registers.
  logic [MASK_W-1:0]  channel_enable_mask;
  logic [LEVEL_W-1:0] trip_level [3];
  logic [GAIN_W-1:0]  gain [3];
  logic [MASK_W-1:0]  immediate_off_mask;

  logic [SLOT_W-1:0]   write_slot;
  logic [SLOT_W-1:0]   write_slot_next;
  logic                filled;

  logic                s1_valid;
  logic                s2_valid;
  logic                out_valid;
  logic [MASK_W-1:0]   s1_rearm;
  logic [MASK_W-1:0]   s2_rearm;

  logic                out_adv;
  logic                s2_ready;
  logic                s1_ready;
  logic                accept;
  logic                s2_en;
  logic                out_en;
  win_ctrl_t           win_ctrl;

  logic [SAMPLE_W-1:0] sample   [3];
  logic [SAMPLE_W-1:0] mean     [3];
  logic [SAMPLE_W-1:0] current  [3];
  chan_state_t         status   [3];
  logic [MASK_W-1:0]   trip_mask;
  logic [MASK_W-1:0]   delatch_mask;
  chan_cfg_t           chan_cfg [3];

  // Handshake chain: each stage moves when the one ahead is empty or moving.
  assign out_adv  = !out_valid || m_tready;
  assign s2_ready = !s2_valid || out_adv;
  assign s1_ready = !s1_valid || s2_ready;
  assign s_tready = s1_ready;
  assign accept   = s_tvalid && s1_ready;
  assign s2_en    = s1_valid && s2_ready;
  assign out_en   = s2_valid && out_adv;

  assign win_ctrl.accept  = accept;
  assign win_ctrl.advance = s2_en;

  assign sample[0] = s_tdata[11:0];
  assign sample[1] = s_tdata[23:12];
  assign sample[2] = s_tdata[35:24];

  assign write_slot_next = !accept ? write_slot :
                           (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable_mask <= ENABLE_RST;
      trip_level[0]       <= LEVEL_RST;
      trip_level[1]       <= LEVEL_RST;
      trip_level[2]       <= LEVEL_RST;
      gain[0]             <= GAIN_ONE_RST;
      gain[1]             <= GAIN_TWO_RST;
      gain[2]             <= GAIN_THR_RST;
      immediate_off_mask  <= IMM_OFF_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index_t'(cfg_index))
        REG_CHANNEL_ENABLE: channel_enable_mask <= cfg_data[MASK_W-1:0];
        REG_TRIP_LEVEL_ONE: trip_level[0]       <= cfg_data[LEVEL_W-1:0];
        REG_TRIP_LEVEL_TWO: trip_level[1]       <= cfg_data[LEVEL_W-1:0];
        REG_TRIP_LEVEL_THR: trip_level[2]       <= cfg_data[LEVEL_W-1:0];
        REG_GAIN_ONE:       gain[0]             <= cfg_data[GAIN_W-1:0];
        REG_GAIN_TWO:       gain[1]             <= cfg_data[GAIN_W-1:0];
        REG_GAIN_THR:       gain[2]             <= cfg_data[GAIN_W-1:0];
        REG_IMMEDIATE_OFF:  immediate_off_mask  <= cfg_data[MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      filled     <= 1'b0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      write_slot <= write_slot_next;
      if (accept && (write_slot == LAST_SLOT)) begin
        filled <= 1'b1;
      end
      s1_valid  <= accept || (s1_valid && !s2_en);
      s2_valid  <= s2_en || (s2_valid && !out_en);
      out_valid <= out_en || (out_valid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rearm <= s_tdata[38:36];
    end
    if (s2_en) begin
      s2_rearm <= s1_rearm;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_chan
    assign chan_cfg[k].enable        = channel_enable_mask[k];
    assign chan_cfg[k].immediate_off = immediate_off_mask[k];
    assign chan_cfg[k].trip_level    = trip_level[k];
    assign chan_cfg[k].gain          = gain[k];

    aold_window #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (win_ctrl),
      .slot      (write_slot),
      .slot_next (write_slot_next),
      .filled    (filled),
      .sample    (sample[k]),
      .mean      (mean[k])
    );

    aold_trip u_trip (
      .clk     (clk),
      .rst     (rst),
      .load    (out_en),
      .cfg     (chan_cfg[k]),
      .rearm   (s2_rearm[k]),
      .mean    (mean[k]),
      .current (current[k]),
      .status  (status[k]),
      .trip    (trip_mask[k]),
      .delatch (delatch_mask[k])
    );
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {delatch_mask, trip_mask, status[2], status[1], status[0],
                     current[2], current[1], current[0]};

endmodule

// ----- rtl/aold_checker.sv -----
// Port-level checks for the averaged overcurrent latch detector, with its bind.
`timescale 1ns / 1ps

module aold_assertions (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [aold_pkg::M_DATA_W-1:0] m_tdata
);
  import aold_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Reset drops any pending result.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A delatch only comes with a trip, on the same channel.
  a_delatch_trip: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[47:45] & ~m_tdata[44:42]) == 3'd0))
    else $error("delatch without trip");

  // Channel one, when tripped, reports OFF when delatched and HOLD otherwise.
  a_trip_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[42] |->
      (m_tdata[45] ? (m_tdata[37:36] == CH_OFF) : (m_tdata[37:36] == CH_HOLD)))
    else $error("channel one state does not match its trip");

  logic unused_in;
  assign unused_in = s_tvalid ^ s_tready;

endmodule

bind averaged_overcurrent_latch_detector aold_assertions u_aold_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
